// ----- rtl/core/lpfd_pkg.sv -----
// Shared types, constants and a helper function for the length-prefixed field deframer.
package lpfd_pkg;

  localparam int unsigned FIELD_W  = 8;
  localparam int unsigned DIGITS_W = 5;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIM_W    = 17;  // wide enough for any length limit or power of ten

  localparam logic [DIGITS_W-1:0] MAX_PREFIX_DIGITS = 5'd20;

  // request action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_DEF   = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_DATA,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_OPEN,
    S_BYTE,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic                action;
    logic [FIELD_W-1:0]  field_number;
    logic [DIGITS_W-1:0] prefix_digits;
    logic [LEN_W-1:0]    max_length;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  out_field;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                field_end;
    logic [LEN_W-1:0]    field_length;
    logic                message_done;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [DIGITS_W-1:0] digits;
  } def_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the request, clear the result
    logic load;        // write one field definition
    logic scan_first;  // start the field search at field zero
    logic scan_step;   // advance the field search
    logic scan_miss;   // no further field: message complete
    logic open;        // take the found definition as current field
    logic byte_proc;   // consume the message byte
    logic emit;        // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic phase_idle;
    logic scan_hit;
    logic scan_none;
    logic field_ended;
    logic out_free;
  } sts_t;

  // Smallest value with more than p decimal digits (saturated above any 15-bit length).
  function automatic logic [LIM_W-1:0] pow10(input logic [DIGITS_W-1:0] p);
    logic [LIM_W-1:0] v;
    case (p)
      5'd0:    v = 17'd1;
      5'd1:    v = 17'd10;
      5'd2:    v = 17'd100;
      5'd3:    v = 17'd1000;
      5'd4:    v = 17'd10000;
      default: v = 17'h1FFFF;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/lpfd_in_if.sv -----
// Request channel: valid/ready handshake carrying one input item.
interface lpfd_in_if import lpfd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lpfd_out_if.sv -----
// Result channel: valid/ready handshake carrying one result item.
interface lpfd_out_if import lpfd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lpfd_ctrl.sv -----
// Sequencing state machine of the deframer.
module lpfd_ctrl import lpfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        first_q, first_d;  // search belongs to the message start

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.is_load) begin
          state_d = S_EMIT;
        end else if (sts_i.phase_idle) begin
          state_d = S_SCAN;
          first_d = 1'b1;
        end else begin
          state_d = S_BYTE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) state_d = S_OPEN;
        else if (sts_i.scan_none) state_d = S_EMIT;
      end
      S_OPEN: begin
        state_d = first_q ? S_BYTE : S_EMIT;
      end
      S_BYTE: begin
        if (sts_i.field_ended) begin
          state_d = S_SCAN;
          first_d = 1'b0;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.load       = sts_i.is_load;
        cmd_o.scan_first = !sts_i.is_load && sts_i.phase_idle;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_miss = sts_i.scan_none;
      end
      S_OPEN:  cmd_o.open = 1'b1;
      S_BYTE:  cmd_o.byte_proc = 1'b1;
      S_EMIT:  cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_byte_needs_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> !sts_i.phase_idle)
    else $error("byte processed with no open field");

  a_open_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OPEN) |-> ($past(state_q) == S_SCAN))
    else $error("field opened without a search hit");

endmodule

// ----- rtl/core/lpfd_dpath.sv -----
// Datapath: definition memory, field search, prefix decode and result register.
module lpfd_dpath import lpfd_pkg::*; #(
  parameter int unsigned NUM_FIELDS    = 129,
  parameter int unsigned MAX_FIELD_LEN = 30000
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_FIELDS);
  localparam int unsigned SCAN_W = IDX_W + 1;
  localparam int unsigned ACC_W  = $clog2(MAX_FIELD_LEN + 2);
  localparam int unsigned MUL_W  = ACC_W + 4;
  localparam int unsigned CMP_W  = (MUL_W > LEN_W) ? MUL_W : LEN_W;

  localparam logic [MUL_W-1:0]  ACC_SAT   = MUL_W'(MAX_FIELD_LEN + 1);
  localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(NUM_FIELDS);
  localparam logic [FIELD_W:0]  FNUM_END  = (FIELD_W + 1)'(NUM_FIELDS);
  localparam logic [LIM_W-1:0]  LEN_LIMIT = LIM_W'(MAX_FIELD_LEN);

  // definition store and its per-entry "defined" flags
  def_entry_t def_mem [NUM_FIELDS];
  def_entry_t rd_data_q;
  logic [NUM_FIELDS-1:0] def_q, def_d;

  in_item_t            item_q, item_d;
  phase_e              phase_q, phase_d;
  logic [FIELD_W-1:0]  cur_field_q, cur_field_d;
  logic [LEN_W-1:0]    bytes_left_q, bytes_left_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [DIGITS_W-1:0] digits_left_q, digits_left_d;
  logic [LEN_W-1:0]    cur_len_q, cur_len_d;
  logic [DIGITS_W-1:0] cur_digits_q, cur_digits_d;
  logic [SCAN_W-1:0]   scan_idx_q, scan_idx_d;
  out_item_t           res_q, res_d;
  logic                done_q, done_d;
  logic                err_q, err_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  // load checks
  logic [IDX_W-1:0]  wr_idx;
  logic              in_range;
  logic              bad_def;
  logic              mem_we;
  def_entry_t        wr_entry;

  // byte decode
  logic              digit_ok;
  logic [MUL_W-1:0]  acc_mul;
  logic [MUL_W-1:0]  acc_sat;
  logic [DIGITS_W-1:0] digits_next;
  logic [LEN_W-1:0]  bytes_next;
  logic              too_long;
  logic              field_ended;
  logic [LEN_W-1:0]  field_len_val;
  logic [SCAN_W-1:0] next_start;
  logic              scan_none;
  logic              scan_hit;

  assign wr_idx   = item_q.field_number[IDX_W-1:0];
  assign in_range = {1'b0, item_q.field_number} < FNUM_END;
  assign bad_def  = (item_q.max_length != '0) &&
                    (({2'b00, item_q.max_length} > LEN_LIMIT) ||
                     (item_q.prefix_digits > MAX_PREFIX_DIGITS) ||
                     ((item_q.prefix_digits != '0) &&
                      ({2'b00, item_q.max_length} >= pow10(item_q.prefix_digits))));
  assign mem_we   = cmd_i.load && in_range && !bad_def;
  assign wr_entry = '{len: item_q.max_length, digits: item_q.prefix_digits};

  always_ff @(posedge clk_i) begin
    if (mem_we) def_mem[wr_idx] <= wr_entry;
    rd_data_q <= def_mem[scan_idx_q[IDX_W-1:0]];
  end

  assign scan_none = scan_idx_q >= SCAN_END;
  assign scan_hit  = !scan_none && def_q[scan_idx_q[IDX_W-1:0]];

  // acc * 10 + digit, saturated one above the length limit
  assign digit_ok = (item_q.data_byte >= CHAR_0) && (item_q.data_byte <= CHAR_9);
  assign acc_mul  = MUL_W'({acc_q, 3'b000}) + MUL_W'({acc_q, 1'b0}) +
                    MUL_W'(item_q.data_byte[3:0]);
  assign acc_sat  = (acc_mul > ACC_SAT) ? ACC_SAT : acc_mul;
  assign digits_next = digits_left_q - DIGITS_W'(1);
  assign bytes_next  = bytes_left_q - LEN_W'(1);
  assign too_long    = CMP_W'(acc_sat) > CMP_W'(cur_len_q);
  assign field_ended = ((phase_q == PH_PREFIX) && digit_ok && (digits_next == '0) &&
                        !too_long && (acc_sat == '0)) ||
                       ((phase_q == PH_DATA) && (bytes_next == '0));
  assign field_len_val = (cur_digits_q == '0) ? cur_len_q : LEN_W'(acc_q);
  assign next_start    = SCAN_W'(cur_field_q) + SCAN_W'(1);

  always_comb begin
    item_d        = item_q;
    def_d         = def_q;
    phase_d       = phase_q;
    cur_field_d   = cur_field_q;
    bytes_left_d  = bytes_left_q;
    acc_d         = acc_q;
    digits_left_d = digits_left_q;
    cur_len_d     = cur_len_q;
    cur_digits_d  = cur_digits_q;
    scan_idx_d    = scan_idx_q;
    res_d         = res_q;
    done_d        = done_q;
    err_d         = err_q;

    if (cmd_i.capture) begin
      item_d = in_item_i;
      res_d  = '0;
      done_d = 1'b0;
      err_d  = 1'b0;
    end

    if (cmd_i.load) begin
      phase_d = PH_IDLE;
      if (in_range) begin
        if (bad_def) res_d.status = ST_BAD_DEF;
        else         def_d[wr_idx] = (item_q.max_length != '0);
      end
    end

    if (cmd_i.scan_first) scan_idx_d = '0;
    if (cmd_i.scan_step && !scan_hit && !scan_none) scan_idx_d = scan_idx_q + SCAN_W'(1);

    if (cmd_i.scan_miss) begin
      phase_d            = PH_SKIP;
      done_d             = 1'b1;
      res_d.message_done = 1'b1;
    end

    if (cmd_i.open) begin
      cur_field_d  = FIELD_W'(scan_idx_q);
      cur_len_d    = rd_data_q.len;
      cur_digits_d = rd_data_q.digits;
      if (rd_data_q.digits != '0) begin
        phase_d       = PH_PREFIX;
        digits_left_d = rd_data_q.digits;
        acc_d         = '0;
      end else begin
        phase_d      = PH_DATA;
        bytes_left_d = rd_data_q.len;
      end
    end

    if (cmd_i.byte_proc) begin
      case (phase_q)
        PH_PREFIX: begin
          res_d.out_field = cur_field_q;
          if (!digit_ok) begin
            res_d.status = ST_BAD_DIGIT;
            err_d        = 1'b1;
            phase_d      = PH_SKIP;
          end else begin
            acc_d         = ACC_W'(acc_sat);
            digits_left_d = digits_next;
            if (digits_next == '0) begin
              if (too_long) begin
                res_d.status = ST_TOO_LONG;
                err_d        = 1'b1;
                phase_d      = PH_SKIP;
              end else if (acc_sat == '0) begin
                res_d.field_end    = 1'b1;
                res_d.field_length = '0;
              end else begin
                phase_d      = PH_DATA;
                bytes_left_d = LEN_W'(acc_sat);
              end
            end
          end
        end
        PH_DATA: begin
          res_d.out_field = cur_field_q;
          res_d.out_byte  = item_q.data_byte;
          res_d.out_valid = 1'b1;
          bytes_left_d    = bytes_next;
          if (bytes_next == '0) begin
            res_d.field_end    = 1'b1;
            res_d.field_length = field_len_val;
          end
        end
        PH_SKIP: done_d = 1'b1;
        default: done_d = done_q;
      endcase
      if (field_ended) scan_idx_d = next_start;
    end

    // end of the message buffer returns the parser to idle
    if (cmd_i.emit && (item_q.action == ACT_BYTE) && item_q.last_byte) phase_d = PH_IDLE;
  end

  always_comb begin
    out_d = res_q;
    if ((item_q.action == ACT_BYTE) && item_q.last_byte && !done_q && !err_q) begin
      out_d.status = ST_TRUNCATED;
    end
    out_valid_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q         <= '0;
      phase_q       <= PH_IDLE;
      cur_field_q   <= '0;
      bytes_left_q  <= '0;
      acc_q         <= '0;
      digits_left_q <= '0;
      scan_idx_q    <= '0;
      done_q        <= 1'b0;
      err_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      def_q         <= def_d;
      phase_q       <= phase_d;
      cur_field_q   <= cur_field_d;
      bytes_left_q  <= bytes_left_d;
      acc_q         <= acc_d;
      digits_left_q <= digits_left_d;
      scan_idx_q    <= scan_idx_d;
      done_q        <= done_d;
      err_q         <= err_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cur_len_q    <= cur_len_d;
    cur_digits_q <= cur_digits_d;
    res_q        <= res_d;
    if (cmd_i.emit) out_q <= out_d;
  end

  assign sts_o.is_load     = (item_q.action == ACT_LOAD);
  assign sts_o.phase_idle  = (phase_q == PH_IDLE);
  assign sts_o.scan_hit    = scan_hit;
  assign sts_o.scan_none   = scan_none;
  assign sts_o.field_ended = field_ended;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_open_defined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open |-> (rd_data_q.len != '0))
    else $error("opened field has no definition");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.message_done) |-> (out_q.status == ST_OK))
    else $error("message completion reported with an error");

  a_content_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_valid) |->
      ((out_q.status == ST_OK) || (out_q.status == ST_TRUNCATED)))
    else $error("content byte carries a prefix error");

endmodule

// ----- rtl/core/length_prefixed_field_deframer.sv -----
// Top level of the length-prefixed field deframer.
//
//   channel  dir  handshake          payload
//   in_i     in   valid / ready      in_item_t  (load definition or message byte)
//   out_o    out  valid / ready      out_item_t (one result per request)
//
// Steps per request: accept, decode, then emit into the output register for a load; a byte
// in a field adds a byte step, and a byte that opens a message or closes a field adds the
// field search and an open step (the open is skipped when no further field is defined).
// Reset (rst_ni low, asynchronous) clears all definitions and parses from idle.
// One request in flight; the next is taken while the last result waits in the output
// register, and a stalled result holds the block only when a new result is ready.
module length_prefixed_field_deframer import lpfd_pkg::*; #(
  parameter int unsigned NUM_FIELDS    = 129,
  parameter int unsigned MAX_FIELD_LEN = 30000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpfd_in_if.sink     in_i,
  lpfd_out_if.source  out_o
);

  cmd_t cmd;      // controller commands
  sts_t sts;      // datapath status
  logic in_ready;

  // Controller: sequences accept, decode, search, open, byte and emit steps.
  lpfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: definition memory, parse state, result and output registers.
  lpfd_dpath #(
    .NUM_FIELDS    (NUM_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.payload),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

  assign in_i.ready = in_ready;

endmodule

// ----- dv/tb_length_prefixed_field_deframer.sv -----
// Self-checking testbench for the length-prefixed field deframer: directed and random traffic.
`timescale 1ns / 100ps

module tb_length_prefixed_field_deframer;
  import lpfd_pkg::*;

  localparam int unsigned FIELD_COUNT = 129;
  localparam int unsigned LEN_LIMIT   = 30000;
  localparam int unsigned CLK_HALF    = 2;
  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned SETTLE_CYC  = 200;   // > worst field search + stall

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Channels; every block input is held at a known value from time zero.
  lpfd_in_if  req_if ();
  lpfd_out_if rsp_if ();

  logic     req_valid = 1'b0;
  in_item_t req_item  = '0;
  logic     rsp_ready = 1'b0;

  assign req_if.valid   = req_valid;
  assign req_if.payload = req_item;
  assign rsp_if.ready   = rsp_ready;

  length_prefixed_field_deframer #(
    .NUM_FIELDS    (FIELD_COUNT),
    .MAX_FIELD_LEN (LEN_LIMIT)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Deframer predictor: definition table plus parse state, stepped once per
  // accepted request. Every request yields exactly one result.
  // ---------------------------------------------------------------------------
  int unsigned tbl_len [FIELD_COUNT];
  int unsigned tbl_dig [FIELD_COUNT];
  int unsigned cur_fld;
  int unsigned left_cnt;     // content bytes still to come
  int unsigned len_acc;      // decoded prefix length (saturating)
  int unsigned dig_left;     // prefix digits still to come
  phase_e      parse_ph;

  out_item_t   expected_results[$];

  // run bookkeeping
  bit          calm = 1'b0;  // no idling on either side while set
  int unsigned fail_count;
  int unsigned req_count, load_count, byte_count, msg_count, rsp_count;
  int unsigned end_count, done_count;
  int unsigned status_hits [8];
  int unsigned stall_left = 0;
  int unsigned rx_wait;

  function automatic void clear_predictor();
    for (int unsigned f = 0; f < FIELD_COUNT; f++) begin
      tbl_len[f] = 0;
      tbl_dig[f] = 0;
    end
    cur_fld  = 0;
    left_cnt = 0;
    len_acc  = 0;
    dig_left = 0;
    parse_ph = PH_IDLE;
  endfunction

  // lowest defined field at or above start; FIELD_COUNT when none
  function automatic int unsigned next_defined(int unsigned start);
    for (int unsigned f = start; f < FIELD_COUNT; f++) begin
      if (tbl_len[f] != 0) return f;
    end
    return FIELD_COUNT;
  endfunction

  function automatic void enter_field(int unsigned f);
    cur_fld = f;
    if (tbl_dig[f] != 0) begin
      parse_ph = PH_PREFIX;
      dig_left = tbl_dig[f];
      len_acc  = 0;
    end else begin
      parse_ph = PH_DATA;
      left_cnt = tbl_len[f];
      len_acc  = tbl_len[f];
    end
  endfunction

  // step past the current field; 1 when it was the last defined one
  function automatic bit leave_field();
    int unsigned f;
    f = next_defined(cur_fld + 1);
    if (f >= FIELD_COUNT) begin
      parse_ph = PH_SKIP;
      return 1'b1;
    end
    enter_field(f);
    return 1'b0;
  endfunction

  function automatic int unsigned digit_count(int unsigned v);
    int unsigned n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // 10**p, clipped above any legal length
  function automatic int unsigned ten_pow(int unsigned p);
    int unsigned v;
    v = 1;
    if (p >= 5) return 100000;
    repeat (p) v = v * 10;
    return v;
  endfunction

  function automatic out_item_t deframe_step(in_item_t rq);
    out_item_t   res;
    bit          done;
    bit          err;
    bit          bad;
    int unsigned f;
    int unsigned acc;
    res  = '0;
    done = 1'b0;
    err  = 1'b0;
    if (rq.action == ACT_LOAD) begin
      // any load drops an ongoing message
      parse_ph = PH_IDLE;
      if (rq.field_number < FIELD_COUNT) begin
        bad = 1'b0;
        if (rq.max_length != 0) begin
          if (rq.max_length > LEN_LIMIT || rq.prefix_digits > MAX_PREFIX_DIGITS) begin
            bad = 1'b1;
          end else if (rq.prefix_digits != 0 &&
                       digit_count(rq.max_length) > rq.prefix_digits) begin
            bad = 1'b1;
          end
        end
        if (bad) begin
          res.status = ST_BAD_DEF;
        end else begin
          tbl_len[rq.field_number] = rq.max_length;
          tbl_dig[rq.field_number] = rq.prefix_digits;
        end
      end
    end else begin
      if (parse_ph == PH_IDLE) begin
        f = next_defined(0);
        if (f >= FIELD_COUNT) begin
          // empty table: the message is complete at once
          parse_ph         = PH_SKIP;
          done             = 1'b1;
          res.message_done = 1'b1;
        end else begin
          enter_field(f);
        end
      end
      if (!done && parse_ph == PH_PREFIX) begin
        res.out_field = FIELD_W'(cur_fld);
        if (rq.data_byte < CHAR_0 || rq.data_byte > CHAR_9) begin
          res.status = ST_BAD_DIGIT;
          err        = 1'b1;
          parse_ph   = PH_SKIP;
        end else begin
          acc = len_acc * 10 + (int'(rq.data_byte) - int'(CHAR_0));
          if (acc > LEN_LIMIT + 1) acc = LEN_LIMIT + 1;
          len_acc  = acc;
          dig_left = (dig_left - 1) & 32'h1F;
          if (dig_left == 0) begin
            if (acc > tbl_len[cur_fld]) begin
              res.status = ST_TOO_LONG;
              err        = 1'b1;
              parse_ph   = PH_SKIP;
            end else if (acc == 0) begin
              // empty variable field closes on its last prefix digit
              res.field_end    = 1'b1;
              done             = leave_field();
              res.message_done = done;
            end else begin
              parse_ph = PH_DATA;
              left_cnt = acc;
            end
          end
        end
      end else if (!done && parse_ph == PH_DATA) begin
        res.out_field = FIELD_W'(cur_fld);
        res.out_byte  = rq.data_byte;
        res.out_valid = 1'b1;
        left_cnt      = (left_cnt - 1) & 32'hFFFF;
        if (left_cnt == 0) begin
          res.field_end    = 1'b1;
          res.field_length = LEN_W'(len_acc);
          done             = leave_field();
          res.message_done = done;
        end
      end else if (!done) begin
        done = 1'b1;  // past the last field or after an error
      end
      if (rq.last_byte) begin
        if (!done && !err) res.status = ST_TRUNCATED;
        parse_ph = PH_IDLE;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_load(int unsigned fnum, int unsigned pdig,
                                         int unsigned mlen);
    in_item_t rq;
    rq               = '0;
    rq.action        = ACT_LOAD;
    rq.field_number  = FIELD_W'(fnum);
    rq.prefix_digits = DIGITS_W'(pdig);
    rq.max_length    = LEN_W'(mlen);
    rq.data_byte     = BYTE_W'($urandom_range(0, 255));   // ignored on loads
    rq.last_byte     = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // load fields other than data_byte/last_byte carry noise on byte requests
  function automatic in_item_t make_byte(int unsigned b, bit last);
    in_item_t rq;
    rq               = '0;
    rq.action        = ACT_BYTE;
    rq.field_number  = FIELD_W'($urandom_range(0, 255));
    rq.prefix_digits = DIGITS_W'($urandom_range(0, 31));
    rq.max_length    = LEN_W'($urandom_range(0, 32767));
    rq.data_byte     = BYTE_W'(b);
    rq.last_byte     = last;
    return rq;
  endfunction

  // well-formed definition; fixed-length fields are kept small so messages stay short
  function automatic in_item_t make_field_load();
    int unsigned fnum;
    int unsigned pdig;
    int unsigned mlen;
    int unsigned lim;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    fnum = (pick == 0) ? 0 : (pick == 1) ? FIELD_COUNT - 1 : $urandom_range(0, FIELD_COUNT - 1);
    if ($urandom_range(0, 1) == 0) begin
      pdig = 0;
      mlen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    end else begin
      pdig = ($urandom_range(0, 5) == 0) ? $urandom_range(5, MAX_PREFIX_DIGITS)
                                         : $urandom_range(1, 4);
      lim  = ten_pow(pdig) - 1;
      if (lim > LEN_LIMIT) lim = LEN_LIMIT;
      case ($urandom_range(0, 2))
        0:       mlen = $urandom_range(1, (lim < 9) ? lim : 9);
        1:       mlen = lim;
        default: mlen = $urandom_range(1, lim);
      endcase
    end
    return make_load(fnum, pdig, mlen);
  endfunction

  // load that never writes the table: out of range or rejected
  function automatic in_item_t make_noise_load();
    int unsigned pdig;
    case ($urandom_range(0, 3))
      0: return make_load($urandom_range(FIELD_COUNT, 255), $urandom_range(0, 31),
                          $urandom_range(0, 32767));
      1: return make_load($urandom_range(0, FIELD_COUNT - 1), $urandom_range(0, 31),
                          $urandom_range(LEN_LIMIT + 1, 32767));
      2: return make_load($urandom_range(0, FIELD_COUNT - 1),
                          $urandom_range(MAX_PREFIX_DIGITS + 1, 31), $urandom_range(1, 32767));
      default: begin
        // prefix too short for the length
        pdig = $urandom_range(1, 4);
        return make_load($urandom_range(0, FIELD_COUNT - 1), pdig,
                         $urandom_range(ten_pow(pdig), LEN_LIMIT));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional gap, then hold valid until ready. The prediction is made
  // at the accepting edge so the expectation is queued before any result.
  // ---------------------------------------------------------------------------
  task automatic send_request(input in_item_t rq);
    int unsigned gap;
    out_item_t   res;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_item  <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    res = deframe_step(rq);
    expected_results.push_back(res);
    req_count++;
    if (rq.action == ACT_LOAD) load_count++;
    else byte_count++;
    if (res.field_end) end_count++;
    if (res.message_done) done_count++;
    status_hits[res.status]++;
  endtask

  // sender stands still until every queued result has come back
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker: random back-pressure drawn after each result.
  // ---------------------------------------------------------------------------
  function automatic void check_result(out_item_t exp_r, out_item_t act_r);
    if (act_r.out_field !== exp_r.out_field) begin
      $error("out_field: expected %0d, got %0d", exp_r.out_field, act_r.out_field);
      fail_count++;
    end
    if (act_r.out_byte !== exp_r.out_byte) begin
      $error("out_byte: expected %0d, got %0d", exp_r.out_byte, act_r.out_byte);
      fail_count++;
    end
    if (act_r.out_valid !== exp_r.out_valid) begin
      $error("out_valid: expected %0d, got %0d", exp_r.out_valid, act_r.out_valid);
      fail_count++;
    end
    if (act_r.field_end !== exp_r.field_end) begin
      $error("field_end: expected %0d, got %0d", exp_r.field_end, act_r.field_end);
      fail_count++;
    end
    if (act_r.field_length !== exp_r.field_length) begin
      $error("field_length: expected %0d, got %0d", exp_r.field_length, act_r.field_length);
      fail_count++;
    end
    if (act_r.message_done !== exp_r.message_done) begin
      $error("message_done: expected %0d, got %0d", exp_r.message_done, act_r.message_done);
      fail_count++;
    end
    if (act_r.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, act_r.status);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_ready) begin
      rsp_count++;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: field %0d status %0d",
               rsp_if.payload.out_field, rsp_if.payload.status);
        fail_count++;
      end else begin
        check_result(expected_results.pop_front(), rsp_if.payload);
      end
      rx_wait = calm ? 0 : $urandom_range(0, 7);
      stall_left <= rx_wait;
      rsp_ready  <= (rx_wait == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      rsp_ready  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Message generator. Walks the current table in field order and builds a
  // well-formed message with random content; about half the messages are then
  // spoiled (corrupted byte, early end, trailing bytes, a load in the middle,
  // or an oversized length prefix).
  // ---------------------------------------------------------------------------
  task automatic run_message();
    in_item_t    msg[$];
    in_item_t    rq;
    logic [7:0]  dg [32];
    int unsigned f, p, len, val, mode, pos, idx, keep;
    bit          stop;
    mode = $urandom_range(0, 9);
    stop = 1'b0;
    f    = next_defined(0);
    while (f < FIELD_COUNT && !stop) begin
      p = tbl_dig[f];
      if (p == 0) begin
        repeat (tbl_len[f]) msg.push_back(make_byte($urandom_range(0, 255), 1'b0));
      end else begin
        // oversized prefix: either one above the limit or all nines (saturates)
        val = ($urandom_range(0, 1) == 0 && digit_count(tbl_len[f] + 1) <= p) ?
              tbl_len[f] + 1 : ten_pow(p) - 1;
        if (mode == 4 && val > tbl_len[f]) begin
          for (int unsigned i = 0; i < p; i++) begin
            dg[i] = CHAR_0 + 8'(val % 10);
            val   = val / 10;
          end
          if (p >= 5 && val != 0) begin
            for (int unsigned i = 0; i < p; i++) dg[i] = CHAR_9;
          end
          stop = 1'b1;
        end else begin
          len = $urandom_range(0, (tbl_len[f] < 8) ? tbl_len[f] : 8);
          if ($urandom_range(0, 5) == 0) len = 0;
          val = len;
          for (int unsigned i = 0; i < p; i++) begin
            dg[i] = CHAR_0 + 8'(val % 10);
            val   = val / 10;
          end
        end
        for (int unsigned i = p; i > 0; i--) msg.push_back(make_byte(dg[i - 1], 1'b0));
        if (!stop) repeat (len) msg.push_back(make_byte($urandom_range(0, 255), 1'b0));
      end
      f = next_defined(f + 1);
    end
    if (msg.size() == 0 || mode == 2 || stop) begin
      repeat ($urandom_range(1, 3)) msg.push_back(make_byte($urandom_range(0, 255), 1'b0));
    end
    if (mode == 0) begin
      idx          = $urandom_range(0, msg.size() - 1);
      rq           = msg[idx];
      rq.data_byte = BYTE_W'($urandom_range(0, 255));
      msg[idx]     = rq;
    end
    if (mode == 1 && msg.size() > 1) begin
      keep = $urandom_range(1, msg.size() - 1);
      while (msg.size() > keep) void'(msg.pop_back());
    end
    pos = $urandom_range(0, msg.size() - 1);
    msg_count++;
    for (int unsigned i = 0; i < msg.size(); i++) begin
      if (mode == 3 && i == pos) send_request(make_noise_load());
      rq           = msg[i];
      rq.last_byte = (i == msg.size() - 1);
      send_request(rq);
    end
  endtask

  // wipe the table, then define a fresh handful of fields (sometimes none)
  task automatic new_layout();
    int unsigned n;
    for (int unsigned f = 0; f < FIELD_COUNT; f++) begin
      if (tbl_len[f] != 0) send_request(make_load(f, $urandom_range(0, 31), 0));
    end
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
    repeat (n) send_request(make_field_load());
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) send_request(make_noise_load());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // table writes: out of range, each rejection rule, absent entry
  task automatic test_definition_loads();
    send_request(make_load(129, 0, 5));
    send_request(make_load(255, 31, 32767));
    send_request(make_load(3, 5, LEN_LIMIT + 1));
    send_request(make_load(3, MAX_PREFIX_DIGITS + 1, 9));
    send_request(make_load(3, 2, 100));
    send_request(make_load(3, 31, 0));    // length 0 stored unchecked
  endtask

  // nothing defined: first byte completes the message, the next is ignored
  task automatic test_empty_table();
    send_request(make_byte(8'h00, 1'b0));
    send_request(make_byte(8'hFF, 1'b1));
  endtask

  task automatic test_directed_messages();
    send_request(make_load(0, 1, 5));
    send_request(make_load(FIELD_COUNT - 1, 5, LEN_LIMIT));
    // field 0 empty, field 128 two bytes, then a trailing byte
    send_request(make_byte(CHAR_0, 1'b0));
    repeat (4) send_request(make_byte(CHAR_0, 1'b0));
    send_request(make_byte(CHAR_0 + 8'd2, 1'b0));
    send_request(make_byte(8'h00, 1'b0));
    send_request(make_byte(8'hFF, 1'b0));
    send_request(make_byte(8'h41, 1'b1));
    // length 6 over a limit of 5
    send_request(make_byte(CHAR_0 + 8'd6, 1'b1));
    // non-digit in the prefix
    send_request(make_byte(CHAR_0 - 8'd1, 1'b1));
    // load mid-message restarts; the short message after it is truncated
    send_request(make_byte(CHAR_0 + 8'd1, 1'b0));
    send_request(make_load(7, 0, 1));
    send_request(make_byte(CHAR_0 + 8'd1, 1'b1));
  endtask

  task automatic test_random_traffic();
    int unsigned round_no;
    round_no = 0;
    while (req_count < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      new_layout();
      repeat ($urandom_range(2, 4)) run_message();
      if (round_no == 2) hold_until_drained();
      round_no++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_predictor();
    fail_count = 0;
    req_count  = 0;
    load_count = 0;
    byte_count = 0;
    msg_count  = 0;
    rsp_count  = 0;
    end_count  = 0;
    done_count = 0;
    for (int i = 0; i < 8; i++) status_hits[i] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_definition_loads();
    test_empty_table();
    test_directed_messages();
    test_random_traffic();

    // let the tail drain, then watch for strays
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end

    $display("covered %0d requests: %0d definition loads, %0d message bytes in %0d messages",
             req_count, load_count, byte_count, msg_count);
    $display("%0d results checked: %0d field ends, %0d completions, status hits %0d/%0d/%0d/%0d",
             rsp_count, end_count, done_count, status_hits[ST_TRUNCATED],
             status_hits[ST_BAD_DIGIT], status_hits[ST_TOO_LONG], status_hits[ST_BAD_DEF]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
